// ===== src/ssfb_pkg.sv =====
// Shared types, codes, segment tables and helper functions of the
// seven-segment frame builder. Depends on nothing; used by every module.
package ssfb_pkg;

	// Default sizes
	localparam int GRID_COUNT_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Request modes
	localparam logic [1:0] MODE_REFRESH = 2'd0;
	localparam logic [1:0] MODE_CLEAR   = 2'd1;
	localparam logic [1:0] MODE_DIM     = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	// Register indexes on the configuration port
	localparam logic REG_DIM_FIRST  = 1'b0;
	localparam logic REG_DIM_SECOND = 1'b1;

	// Chip commands
	localparam logic [7:0] CMD_WRITE_INC = 8'h40;
	localparam logic [7:0] CMD_ADDR_ZERO = 8'hC0;
	localparam logic [7:0] CMD_DIM_HIGH  = 8'h8A;
	localparam logic [7:0] CMD_DIM_MID   = 8'h89;
	localparam logic [7:0] CMD_DIM_LOW   = 8'h80;

	// Segment patterns for letters and marks
	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam logic [7:0] SEG_DASH  = 8'h40;
	localparam logic [7:0] DOT_BIT   = 8'h80;
	localparam logic [7:0] SEG_U     = 8'h3E;
	localparam logic [7:0] SEG_P     = 8'h73;
	localparam logic [7:0] SEG_E     = 8'h79;
	localparam logic [7:0] SEG_L     = 8'h38;
	localparam logic [7:0] SEG_R     = 8'h31;
	localparam logic [7:0] SEG_A     = 8'h77;
	localparam logic [7:0] SEG_D     = 8'h3F;
	localparam logic [7:0] SEG_S     = 8'h6D;
	localparam logic [7:0] SEG_B     = 8'h7F;
	localparam logic [7:0] SEG_C     = 8'h39;

	// Position codes above the digits
	localparam logic [7:0] CODE_100 = 8'd100;
	localparam logic [7:0] CODE_101 = 8'd101;
	localparam logic [7:0] CODE_110 = 8'd110;
	localparam logic [7:0] CODE_111 = 8'd111;
	localparam logic [7:0] CODE_112 = 8'd112;
	localparam logic [7:0] CODE_DIGIT_MAX = 8'd9;

	// Colon selections
	localparam logic [7:0] COLON_BOTH   = 8'd1;
	localparam logic [7:0] COLON_SECOND = 8'd2;

	// One request as it travels from the front to the back
	typedef struct packed {
		logic [1:0]      mode;
		logic [7:0][7:0] seg;
		logic [7:0]      dim_first;
		logic [7:0]      dim_second;
	} ssfb_cmd_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} ssfb_qstat_t;

	// Standard digit wiring
	function automatic logic [7:0] std_digit(input logic [3:0] d);
		logic [7:0] s;
		begin
			case (d)
				4'd0: s = 8'h3F;
				4'd1: s = 8'h06;
				4'd2: s = 8'h5B;
				4'd3: s = 8'h4F;
				4'd4: s = 8'h66;
				4'd5: s = 8'h6D;
				4'd6: s = 8'h7D;
				4'd7: s = 8'h07;
				4'd8: s = 8'h7F;
				4'd9: s = 8'h6F;
				default: s = SEG_BLANK;
			endcase
			return s;
		end
	endfunction

	// Alternate digit wiring of the first two positions
	function automatic logic [7:0] alt_digit(input logic [3:0] d);
		logic [7:0] s;
		begin
			case (d)
				4'd0: s = 8'h9F;
				4'd1: s = 8'h03;
				4'd2: s = 8'hAD;
				4'd3: s = 8'hA7;
				4'd4: s = 8'h33;
				4'd5: s = 8'hB6;
				4'd6: s = 8'hBE;
				4'd7: s = 8'h83;
				4'd8: s = 8'hBF;
				4'd9: s = 8'hB7;
				default: s = SEG_BLANK;
			endcase
			return s;
		end
	endfunction

	// Brightness index to command; index three saturates to the lowest
	function automatic logic [7:0] dim_code(input logic [1:0] level);
		logic [7:0] c;
		begin
			case (level)
				2'd0:    c = CMD_DIM_HIGH;
				2'd1:    c = CMD_DIM_MID;
				default: c = CMD_DIM_LOW;
			endcase
			return c;
		end
	endfunction

endpackage

// ===== src/ssfb_front.sv =====
// Front of the frame builder: takes requests and turns the position codes
// into segment bytes and brightness commands. Uses ssfb_pkg.
module ssfb_front
	import ssfb_pkg::*;
(
	input  logic        push,
	input  logic [1:0]  mode,
	input  logic [7:0]  level_tens,
	input  logic [7:0]  level_units,
	input  logic [7:0]  track_tens,
	input  logic [7:0]  track_units,
	input  logic [7:0]  minute_tens,
	input  logic [7:0]  minute_units,
	input  logic [7:0]  second_tens,
	input  logic [7:0]  second_units,
	input  logic [7:0]  colon_mode,
	input  logic [1:0]  dim_level_first,
	input  logic [1:0]  dim_level_second,
	input  ssfb_qstat_t qstat,
	output logic        full,
	output logic        q_wr,
	output ssfb_cmd_t   q_data
);

	logic [7:0] dot1;
	logic [7:0] dot2;
	logic [7:0][7:0] seg;

	// Accept when the queue has room; drop the unused mode here
	assign full = qstat.full;
	assign q_wr = push && !qstat.full && (mode != MODE_NONE);

	// Colon dots go on the first two positions of the second chip
	assign dot1 = (colon_mode == COLON_BOTH) ? DOT_BIT : SEG_BLANK;
	assign dot2 = ((colon_mode == COLON_BOTH) || (colon_mode == COLON_SECOND)) ?
		DOT_BIT : SEG_BLANK;

	// Decode each position
	always_comb begin
		seg[0] = (level_tens  <= CODE_DIGIT_MAX) ? alt_digit(level_tens[3:0])  : SEG_BLANK;
		seg[1] = (level_units <= CODE_DIGIT_MAX) ? alt_digit(level_units[3:0]) : SEG_BLANK;

		if (track_tens <= CODE_DIGIT_MAX) begin
			seg[2] = std_digit(track_tens[3:0]);
		end else begin
			case (track_tens)
				CODE_100: seg[2] = SEG_U;
				CODE_101: seg[2] = SEG_DASH;
				default:  seg[2] = SEG_BLANK;
			endcase
		end

		if (track_units <= CODE_DIGIT_MAX) begin
			seg[3] = std_digit(track_units[3:0]);
		end else begin
			case (track_units)
				CODE_100: seg[3] = SEG_P;
				CODE_101: seg[3] = SEG_DASH;
				default:  seg[3] = SEG_BLANK;
			endcase
		end

		if (minute_tens <= CODE_DIGIT_MAX) begin
			seg[4] = std_digit(minute_tens[3:0]) | dot1;
		end else begin
			case (minute_tens)
				CODE_100: seg[4] = SEG_DASH;
				CODE_101: seg[4] = SEG_E;
				CODE_110: seg[4] = SEG_L;
				default:  seg[4] = SEG_BLANK;
			endcase
		end

		if (minute_units <= CODE_DIGIT_MAX) begin
			seg[5] = std_digit(minute_units[3:0]) | dot2;
		end else begin
			case (minute_units)
				CODE_100: seg[5] = SEG_DASH;
				CODE_101: seg[5] = SEG_R;
				CODE_110: seg[5] = SEG_A;
				CODE_111: seg[5] = SEG_D;
				CODE_112: seg[5] = SEG_S;
				default:  seg[5] = SEG_BLANK;
			endcase
		end

		if (second_tens <= CODE_DIGIT_MAX) begin
			seg[6] = std_digit(second_tens[3:0]);
		end else begin
			case (second_tens)
				CODE_100: seg[6] = SEG_DASH;
				CODE_101: seg[6] = SEG_R;
				CODE_110: seg[6] = SEG_A;
				CODE_111: seg[6] = SEG_B;
				default:  seg[6] = SEG_BLANK;
			endcase
		end

		if (second_units <= CODE_DIGIT_MAX) begin
			seg[7] = std_digit(second_units[3:0]);
		end else begin
			case (second_units)
				CODE_100: seg[7] = SEG_DASH;
				CODE_110: seg[7] = SEG_C;
				default:  seg[7] = SEG_BLANK;
			endcase
		end
	end

	// Pack the request for the queue
	always_comb begin
		q_data.mode       = mode;
		q_data.seg        = seg;
		q_data.dim_first  = dim_code(dim_level_first);
		q_data.dim_second = dim_code(dim_level_second);
	end

endmodule

// ===== src/ssfb_cmd_queue.sv =====
// Short request queue between front and back of the frame builder.
// Register-based, depth of at least two. Uses ssfb_pkg.
module ssfb_cmd_queue
	import ssfb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  ssfb_cmd_t   wr_data,
	input  logic        rd,
	output ssfb_cmd_t   rd_data,
	output ssfb_qstat_t qstat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ssfb_cmd_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);
	assign do_wr       = wr && !qstat.full;
	assign do_rd       = rd && !qstat.empty;
	assign rd_data     = entry_q[rd_ptr_q];

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/ssfb_back.sv =====
// Back of the frame builder: walks the request at the queue head and, unless
// stalled, puts out one byte per cycle via an output register. Uses ssfb_pkg.
module ssfb_back
	import ssfb_pkg::*;
#(
	parameter int GRID_COUNT = GRID_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ssfb_cmd_t   cmd,
	input  ssfb_qstat_t qstat,
	output logic        q_rd,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  data_byte,
	output logic        target_chip,
	output logic        opens_frame,
	output logic        closes_frame,
	output logic        last_result
);

	localparam int BODY_MAX = (2 * GRID_COUNT > 8) ? 2 * GRID_COUNT : 8;
	localparam int IDX_W    = $clog2(BODY_MAX + 2);
	localparam logic [IDX_W-1:0] IDX_HEAD = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_ADDR = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_BODY = IDX_W'(2);
	localparam logic [IDX_W-1:0] REF_LAST = IDX_W'(9);
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(2 * GRID_COUNT + 1);

	logic [IDX_W-1:0] idx_q;
	logic             chip_q;
	logic             out_valid_q;
	logic [7:0]       data_q;
	logic             chip_out_q;
	logic             opens_q;
	logic             closes_q;
	logic             last_q;

	logic             load;
	logic             issue;
	logic [IDX_W-1:0] body;
	logic [2:0]       seg_sel;
	logic [7:0]       byte_n;
	logic             opens_n;
	logic             closes_n;
	logic             step_last;
	logic             chip_done;

	// Output register takes a new byte when empty or being drained
	assign load  = !out_valid_q || pop;
	assign issue = load && !qstat.empty;
	assign q_rd  = issue && step_last;

	assign body    = idx_q - IDX_BODY;
	assign seg_sel = {chip_q, body[2:1]};

	// Decode the current step of the request
	always_comb begin
		byte_n    = SEG_BLANK;
		opens_n   = 1'b0;
		closes_n  = 1'b0;
		step_last = 1'b1;
		chip_done = 1'b0;
		unique case (cmd.mode) inside
			MODE_REFRESH, MODE_CLEAR: begin
				if (idx_q == IDX_HEAD) begin
					byte_n   = CMD_WRITE_INC;
					opens_n  = 1'b1;
					closes_n = 1'b1;
				end else if (idx_q == IDX_ADDR) begin
					byte_n  = CMD_ADDR_ZERO;
					opens_n = 1'b1;
				end else if (cmd.mode == MODE_REFRESH) begin
					byte_n   = cmd.seg[seg_sel];
					closes_n = (idx_q == REF_LAST);
				end else begin
					closes_n = (idx_q == CLR_LAST);
				end
				chip_done = closes_n && (idx_q != IDX_HEAD);
				step_last = chip_done && chip_q;
			end
			MODE_DIM: begin
				byte_n    = chip_q ? cmd.dim_second : cmd.dim_first;
				opens_n   = 1'b1;
				closes_n  = 1'b1;
				chip_done = 1'b1;
				step_last = chip_q;
			end
			default: begin
				step_last = 1'b1;
			end
		endcase
	end

	// Advance through the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			chip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (step_last) begin
					idx_q  <= '0;
					chip_q <= 1'b0;
				end else if (chip_done) begin
					idx_q  <= '0;
					chip_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= issue;
			end
		end
	end

	// Hold the byte until it is taken
	always_ff @(posedge clk) begin
		if (issue) begin
			data_q     <= byte_n;
			chip_out_q <= chip_q;
			opens_q    <= opens_n;
			closes_q   <= closes_n;
			last_q     <= step_last;
		end
	end

	assign empty        = !out_valid_q;
	assign data_byte    = data_q;
	assign target_chip  = chip_out_q;
	assign opens_frame  = opens_q;
	assign closes_frame = closes_q;
	assign last_result  = last_q;

endmodule

// ===== src/seven_segment_frame_builder_unit.sv =====
// Top level of the seven-segment frame builder: configuration registers,
// front decoder, request queue and byte sequencer.
// Depends on ssfb_pkg, ssfb_front, ssfb_cmd_queue and ssfb_back.
//
// Use: requests enter through a queue-like port (push/full) carrying a mode
// and eight position codes. Byte transfers leave through a queue-like port
// (empty/pop), each tagged with the chip strobe, the frame open/close points
// and a flag on the final byte of the request.
// A refresh gives 20 bytes, a clear 4 + 4*GRID_COUNT (36 at default), a dim
// two; mode 3 is taken and gives nothing.
// When the block is idle, a taken request is written into the queue and
// then its first byte is loaded into the output register and shows.
// While the receiver pops, the sequencer puts out one byte per cycle; a
// request already queued starts in the cycle after the previous one's
// last byte.
// Up to QUEUE_DEPTH decoded requests wait in the queue; full rises when it
// holds that many.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits; the queue keeps taking requests until full.
// Reset empties queue and output register, and sets brightness indexes of
// the first and second chip to 0 and 1.
// The configuration port (APB, pready always high) holds the two brightness
// indexes at byte addresses 0 and 4.
module seven_segment_frame_builder_unit
	import ssfb_pkg::*;
#(
	parameter int GRID_COUNT  = GRID_COUNT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Requests
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  level_tens,
	input  logic [7:0]  level_units,
	input  logic [7:0]  track_tens,
	input  logic [7:0]  track_units,
	input  logic [7:0]  minute_tens,
	input  logic [7:0]  minute_units,
	input  logic [7:0]  second_tens,
	input  logic [7:0]  second_units,
	input  logic [7:0]  colon_mode,
	// Byte transfers
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  data_byte,
	output logic        target_chip,
	output logic        opens_frame,
	output logic        closes_frame,
	output logic        last_result,
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]  dim_first_q;
	logic [1:0]  dim_second_q;
	logic        cfg_wr;
	logic        q_wr;
	logic        q_rd;
	ssfb_cmd_t   q_wdata;
	ssfb_cmd_t   q_rdata;
	ssfb_qstat_t qstat;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_first_q  <= 2'd0;
			dim_second_q <= 2'd1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DIM_FIRST:  dim_first_q  <= pwdata[1:0];
				REG_DIM_SECOND: dim_second_q <= pwdata[1:0];
				default:        dim_first_q  <= dim_first_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_DIM_SECOND) ? {30'd0, dim_second_q} :
		{30'd0, dim_first_q};

	ssfb_front u_front (
		.push             (push),
		.mode             (mode),
		.level_tens       (level_tens),
		.level_units      (level_units),
		.track_tens       (track_tens),
		.track_units      (track_units),
		.minute_tens      (minute_tens),
		.minute_units     (minute_units),
		.second_tens      (second_tens),
		.second_units     (second_units),
		.colon_mode       (colon_mode),
		.dim_level_first  (dim_first_q),
		.dim_level_second (dim_second_q),
		.qstat            (qstat),
		.full             (full),
		.q_wr             (q_wr),
		.q_data           (q_wdata)
	);

	ssfb_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.qstat   (qstat)
	);

	ssfb_back #(
		.GRID_COUNT (GRID_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (q_rdata),
		.qstat        (qstat),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.data_byte    (data_byte),
		.target_chip  (target_chip),
		.opens_frame  (opens_frame),
		.closes_frame (closes_frame),
		.last_result  (last_result)
	);

	// The final byte of a request always closes a frame
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_result) |-> closes_frame)
		else $error("last byte of a request does not close its frame");

	// A write-mode command frame is one byte long
	a_cmd_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && opens_frame && data_byte == CMD_WRITE_INC) |-> closes_frame)
		else $error("command frame left open");

	// An idle block shows a new request's first byte via queue and output register
	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && mode != MODE_NONE && empty && qstat.empty) |-> ##2 !empty)
		else $error("first byte of a request did not appear");

endmodule
